// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers, compiled out when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_SAME(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular deque package
// Word, operation and status types and the control bundle of the cell row.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int WORD_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load_back;
   } cell_ctrl_type;

   typedef struct packed {
      status_type status;
      logic       read_front;
      logic       read_back;
   } result_type;

endpackage

// ===== rtl/cdq_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one deque operation and its push word.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   import cdq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   word_type            push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);

endinterface

// ===== rtl/cdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the result word of one deque operation.
// ----------------------------------------------------------------------------
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                valid;
   logic                ready;
   word_type            read_value;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   logic                is_empty;
   logic                is_full;

   modport source (output valid, output read_value, output status, output entry_count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input read_value, input status, input entry_count,
                   input is_empty, input is_full, output ready);

endinterface

// ===== rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the row; shifts with its neighbours or loads at the back.
// ----------------------------------------------------------------------------
module cdq_cell #(
   parameter  int INDEX = 0,
   parameter  int DEPTH = 16,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  cdq_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]         count,
   input  cdq_pkg::word_type     push_value,
   input  cdq_pkg::word_type     left_data,
   input  cdq_pkg::word_type     right_data,
   output cdq_pkg::word_type     data,
   output logic                  is_last
);
   import cdq_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      priority if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.load_back && (count == CW'(INDEX))) begin
         data_in = push_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign is_last = (count == CW'(INDEX + 1));

endmodule

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque control
// Holds the word count, decodes operations and drives the cell row.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
   parameter  int DEPTH = 16,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [cdq_pkg::OP_W-1:0] operation,
   output cdq_pkg::cell_ctrl_type cell_ctrl,
   output cdq_pkg::result_type    res,
   output logic [CW-1:0]          count,
   output logic [CW-1:0]          count_next
);
   import cdq_pkg::*;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          empty;
   logic          full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));

   always_comb begin
      count_in             = count_ff;
      cell_ctrl            = '0;
      res.status           = ST_OK;
      res.read_front       = 1'b0;
      res.read_back        = 1'b0;
      if (accept) begin
         unique case (op_type'(operation))
            OP_PUSH_FRONT: begin
               if (full) begin
                  res.status = ST_FULL;
               end else begin
                  cell_ctrl.shift_right = 1'b1;
                  count_in              = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  res.status = ST_FULL;
               end else begin
                  cell_ctrl.load_back = 1'b1;
                  count_in            = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.read_front       = 1'b1;
                  cell_ctrl.shift_left = 1'b1;
                  count_in             = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.read_back = 1'b1;
                  count_in      = count_ff - 1'b1;
               end
            end
            OP_PEEK_FRONT: begin
               if (empty) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.read_front = 1'b1;
               end
            end
            OP_PEEK_BACK: begin
               if (empty) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.read_back = 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The result word is registered and appears in the cycle after its request word is taken.
// Throughput: one word per cycle unless a response stalls; row and count update as one.
// The back word is taken through a one-hot select across the cells.
// Reset clears the count and the response valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
module circular_deque #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req,
   cdq_rsp_if.source rsp
);
   import cdq_pkg::*;

   `include "assert_macros.svh"

   localparam int CW = $clog2(DEPTH + 1);

   logic          accept;
   cell_ctrl_type cell_ctrl;
   result_type    res;
   logic [CW-1:0] count;
   logic [CW-1:0] count_next;
   word_type      cell_data [DEPTH];
   logic [DEPTH-1:0] cell_last;
   word_type      back_value;
   word_type      read_value_in;

   logic                rsp_valid_ff;
   word_type            read_value_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_W-1:0]  entry_count_ff;
   logic                is_empty_ff;
   logic                is_full_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req.operation),
      .cell_ctrl  (cell_ctrl),
      .res        (res),
      .count      (count),
      .count_next (count_next)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_data;
      word_type right_data;

      if (i == 0) begin : g_first
         assign left_data = req.push_value;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      cdq_cell #(.INDEX(i), .DEPTH(DEPTH)) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count),
         .push_value (req.push_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .is_last    (cell_last[i])
      );
   end

   always_comb begin
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_last[i]) begin
            back_value = back_value | cell_data[i];
         end
      end
   end

   always_comb begin
      priority if (res.read_front) begin
         read_value_in = cell_data[0];
      end else if (res.read_back) begin
         read_value_in = back_value;
      end else begin
         read_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff  <= read_value_in;
         status_ff      <= res.status;
         entry_count_ff <= COUNT_W'(count_next);
         is_empty_ff    <= (count_next == '0);
         is_full_ff     <= (count_next == CW'(DEPTH));
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_value  = read_value_ff;
   assign rsp.status      = status_ff;
   assign rsp.entry_count = entry_count_ff;
   assign rsp.is_empty    = is_empty_ff;
   assign rsp.is_full     = is_full_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count <= CW'(DEPTH))
   `ASSERT_SAME(a_read_not_empty, clock, reset, accept && (res.read_front || res.read_back), count != '0)
   `ASSERT_NEXT(a_push_grows, clock, reset, accept && (cell_ctrl.shift_right || cell_ctrl.load_back), count == CW'($past(count) + 1'b1))
   `ASSERT_SAME(a_full_flag, clock, reset, rsp_valid_ff && (status_ff == ST_FULL), is_full_ff)

endmodule

// ===== verif/tb_circular_deque.sv =====
// ----------------------------------------------------------------------------
// Circular deque testbench
// Drives push, pop, peek and clear words into the deque and predicts every
// response from a ring store of its own. Responses are checked field by
// field in order. A directed opening is followed by fill, drain and mixed
// random runs with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_circular_deque;
   import cdq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;
   localparam int PLAN_ITEMS  = 1860;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic            wait_drain;
      logic [OP_W-1:0] op;
      word_type        value;
   } deque_cmd;

   typedef struct packed {
      word_type           read_value;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
      logic               is_full;
   } deque_result;

   logic clock;
   logic reset;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque #(.DEPTH(DEPTH)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   word_type    ring[DEPTH];
   int          front_pos;
   int          back_pos;
   int          held;

   deque_cmd    cmd_plan[$];
   deque_result due_results[$];
   int          next_cmd;
   int          accepted_count;
   int          checked_count;
   int          mismatch_count;
   int          stall_cycles;
   int          cycle_no;
   logic        req_fired;

   int          n_push, n_pop, n_peek, n_clear, n_full_rej, n_empty_rej, peak_fill;

   function automatic int pos_prev(input int p);
      return (p == 0) ? DEPTH - 1 : p - 1;
   endfunction

   function automatic int pos_next(input int p);
      return (p == DEPTH - 1) ? 0 : p + 1;
   endfunction

   function automatic deque_result deque_apply(input logic [OP_W-1:0] op, input word_type value);
      deque_result r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            n_push++;
            if (held == DEPTH) begin
               r.status = ST_FULL;
               n_full_rej++;
            end else if (held == 0) begin
               front_pos = 0;
               back_pos  = 0;
               ring[0]   = value;
               held      = 1;
            end else if (op == OP_PUSH_FRONT) begin
               front_pos       = pos_prev(front_pos);
               ring[front_pos] = value;
               held++;
            end else begin
               back_pos       = pos_next(back_pos);
               ring[back_pos] = value;
               held++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (op == OP_POP_FRONT || op == OP_POP_BACK) n_pop++;
            else n_peek++;
            if (held == 0) begin
               r.status = ST_EMPTY;
               n_empty_rej++;
            end else if (op == OP_POP_FRONT) begin
               r.read_value = ring[front_pos];
               front_pos    = pos_next(front_pos);
               held--;
            end else if (op == OP_POP_BACK) begin
               r.read_value = ring[back_pos];
               back_pos     = pos_prev(back_pos);
               held--;
            end else if (op == OP_PEEK_FRONT) begin
               r.read_value = ring[front_pos];
            end else begin
               r.read_value = ring[back_pos];
            end
         end
         OP_CLEAR: begin
            n_clear++;
            front_pos = 0;
            back_pos  = 0;
            held      = 0;
         end
         default: ;
      endcase
      if (held > peak_fill) peak_fill = held;
      r.entry_count = held[COUNT_W-1:0];
      r.is_empty    = (held == 0);
      r.is_full     = (held == DEPTH);
      return r;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_push();
      return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [OP_W-1:0] pick_read();
      case ($urandom_range(3))
         0:       return OP_POP_FRONT;
         1:       return OP_POP_BACK;
         2:       return OP_PEEK_FRONT;
         default: return OP_PEEK_BACK;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int mode);
      int roll;
      int push_share;
      roll       = $urandom_range(99);
      push_share = (mode == 0) ? 70 : (mode == 1) ? 25 : 50;
      if (roll == 99) return OP_CLEAR;
      if (roll < push_share) return pick_push();
      return pick_read();
   endfunction

   function automatic logic calm_window();
      return cycle_no >= 600 && cycle_no < 1000;
   endfunction

   task automatic plan_cmd(input logic [OP_W-1:0] op, input word_type value,
                           input logic wait_drain = 1'b0);
      deque_cmd c;
      c.wait_drain = wait_drain;
      c.op         = op;
      c.value      = value;
      cmd_plan.push_back(c);
   endtask

   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin : drive
      logic offer;
      offer = 1'b0;
      if (!reset) begin
         if (req_ch.valid && !req_fired) begin
            offer = 1'b1;
         end else if (next_cmd < cmd_plan.size()
                      && !(!calm_window() && $urandom_range(99) < 9)
                      && (!cmd_plan[next_cmd].wait_drain || due_results.size() == 0)) begin
            offer                = 1'b1;
            req_ch.operation  <= cmd_plan[next_cmd].op;
            req_ch.push_value <= cmd_plan[next_cmd].value;
            next_cmd++;
         end
      end
      req_ch.valid <= offer;
      rsp_ch.ready <= !reset && !(!calm_window() && $urandom_range(99) < 9);
   end

   always @(posedge clock) begin : observe
      deque_result want;
      deque_result got;
      logic        req_hit;
      logic        rsp_hit;
      req_hit = req_ch.valid && req_ch.ready;
      rsp_hit = rsp_ch.valid && rsp_ch.ready;
      if (reset) begin
         req_fired    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         cycle_no <= cycle_no + 1;
         req_fired <= req_hit;
         if (req_hit) begin
            due_results.push_back(deque_apply(req_ch.operation, req_ch.push_value));
            accepted_count++;
         end
         if (rsp_hit) begin
            got.read_value  = rsp_ch.read_value;
            got.status      = status_type'(rsp_ch.status);
            got.entry_count = rsp_ch.entry_count;
            got.is_empty    = rsp_ch.is_empty;
            got.is_full     = rsp_ch.is_full;
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0d: response word with nothing outstanding", cycle_no);
            end else begin
               want = due_results.pop_front();
               checked_count++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"%0d: word %0d mismatch: value %0d/%0d status %0d/%0d ",
                               "count %0d/%0d empty %0b/%0b full %0b/%0b (exp/act)"},
                              cycle_no, checked_count,
                              want.read_value, got.read_value, want.status, got.status,
                              want.entry_count, got.entry_count, want.is_empty, got.is_empty,
                              want.is_full, got.is_full);
               end
            end
         end
         stall_cycles <= (req_hit || rsp_hit) ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0d: no handshake for %0d cycles, %0d responses outstanding",
               cycle_no, STALL_LIMIT, due_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int mode;
      int run_len;
      int seg;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_CLEAR;
      req_ch.push_value = '0;
      rsp_ch.ready      = 1'b0;
      next_cmd          = 0;
      accepted_count    = 0;
      checked_count     = 0;
      mismatch_count    = 0;
      cycle_no          = 0;
      front_pos         = 0;
      back_pos          = 0;
      held              = 0;
      n_push = 0; n_pop = 0; n_peek = 0; n_clear = 0;
      n_full_rej = 0; n_empty_rej = 0; peak_fill = 0;

      plan_cmd(OP_POP_FRONT,  '0);
      plan_cmd(OP_POP_BACK,   '0);
      plan_cmd(OP_PEEK_FRONT, '0);
      plan_cmd(OP_PEEK_BACK,  '0);
      plan_cmd(OP_UNUSED,     32'sh1234_5678);
      plan_cmd(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      plan_cmd(OP_PUSH_BACK,  32'sh8000_0000);
      plan_cmd(OP_PEEK_FRONT, '0);
      plan_cmd(OP_PEEK_BACK,  '0);
      plan_cmd(OP_UNUSED,     '1);
      plan_cmd(OP_POP_BACK,   '0);
      plan_cmd(OP_POP_FRONT,  '0);
      plan_cmd(OP_PUSH_BACK,  '1);
      plan_cmd(OP_PUSH_FRONT, '0);
      plan_cmd(OP_PEEK_FRONT, '0);
      plan_cmd(OP_POP_FRONT,  '0);
      plan_cmd(OP_PUSH_FRONT, 32'sh5555_AAAA);
      plan_cmd(OP_CLEAR,      '0);
      plan_cmd(OP_PEEK_BACK,  '0);
      plan_cmd(OP_PUSH_FRONT, 32'sh0000_0001);
      plan_cmd(OP_POP_BACK,   '0);

      // fill past capacity, then drain past empty
      plan_cmd(pick_push(), pick_word(), 1'b1);
      repeat (DEPTH + 2) plan_cmd(pick_push(), pick_word());
      plan_cmd(OP_PEEK_FRONT, '0);
      plan_cmd(OP_PEEK_BACK,  '0);
      repeat (DEPTH + 2) plan_cmd($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, '0);

      seg = 0;
      while (cmd_plan.size() < PLAN_ITEMS) begin
         mode    = $urandom_range(2);
         run_len = $urandom_range(60, 10);
         plan_cmd(pick_op(mode), pick_word(), seg % 7 == 6);
         repeat (run_len - 1) plan_cmd(pick_op(mode), pick_word());
         seg++;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == cmd_plan.size() && due_results.size() == 0);
      repeat (8) @(posedge clock);

      $display("Ran %0d operations: %0d push, %0d pop, %0d peek, %0d clear; %0d words checked.",
               accepted_count, n_push, n_pop, n_peek, n_clear, checked_count);
      $display("Rejected %0d pushes when full and %0d reads when empty; peak fill %0d of %0d.",
               n_full_rej, n_empty_rej, peak_fill, DEPTH);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
